FILE: design/stf_pkg.sv
`default_nettype none
package stf_pkg;

    localparam int KEY_W = 16;
    localparam int ID_W  = 31;
    localparam int CNT_W = 7;
    localparam int MIN_W = 32;

    // last id that is never handed out
    localparam logic [ID_W-1:0] ID_LIMIT = {ID_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_PUSH       = 2'd0,
        MODE_COUNT_ALL  = 2'd1,
        MODE_COUNT_KEY  = 2'd2,
        MODE_INVALIDATE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_IDS_OUT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_HOLD
    } t_state;

    typedef struct packed {
        t_mode                    mode;
        logic [KEY_W-1:0]         key;
        logic signed [MIN_W-1:0]  minimum_id;
    } t_stf_in;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ID_W-1:0]  assigned_id;
        t_status          status;
    } t_stf_out;

endpackage
`default_nettype wire

FILE: design/stf_mem.sv
`default_nettype none
module stf_mem #(
    parameter int DEPTH = 64,
    parameter int DW    = 47
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DW-1:0]            i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/stf_ctrl.sv
`default_nettype none
module stf_ctrl
    import stf_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_stf_in  i_in_beat,
    output logic          o_res_vld,
    output t_stf_out      o_res,
    input  wire logic     i_res_free
);

    localparam int PW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);
    localparam int KB = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int DW = KB + ID_W;

    t_state                  r_state, n_state;
    logic [PW-1:0]           r_head, n_head;
    logic [OW-1:0]           r_occ, n_occ;
    logic [ID_W-1:0]         r_next_id, n_next_id;
    logic [PW-1:0]           r_rptr, n_rptr;
    logic [OW-1:0]           r_num, n_num;
    logic [OW-1:0]           r_cnt, n_cnt;
    t_mode                   r_mode, n_mode;
    logic [KB-1:0]           r_key, n_key;
    logic signed [MIN_W-1:0] r_min, n_min;
    t_stf_out                r_res, n_res;

    logic                    mem_we, mem_re;
    logic [PW-1:0]           mem_waddr, mem_raddr;
    logic [DW-1:0]           mem_wdata, mem_rdata;

    logic [PW:0]             tail_sum, tail_wrap;
    logic [PW-1:0]           tail_slot;
    logic [KB-1:0]           rd_key;
    logic [ID_W-1:0]         rd_id;
    logic                    below, match;
    logic [OW-1:0]           cnt_nxt;
    logic [CNT_W+OW-1:0]     occ_ext, cnt_ext;
    t_stf_out                res;
    logic                    res_vld;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    stf_mem #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // tail slot = (head + occupancy) mod DEPTH, head below DEPTH, occupancy at most DEPTH
    assign tail_sum  = {1'b0, r_head} + (PW+1)'(r_occ);
    assign tail_wrap = tail_sum - (PW+1)'(DEPTH);
    assign tail_slot = (tail_sum >= (PW+1)'(DEPTH)) ? tail_wrap[PW-1:0] : tail_sum[PW-1:0];

    assign rd_key  = mem_rdata[DW-1:ID_W];
    assign rd_id   = mem_rdata[ID_W-1:0];
    assign below   = $signed({1'b0, rd_id}) < r_min;
    assign match   = (rd_key == r_key);
    assign cnt_nxt = r_cnt + OW'(match);
    assign occ_ext = {{CNT_W{1'b0}}, r_occ};
    assign cnt_ext = {{CNT_W{1'b0}}, cnt_nxt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_occ     <= '0;
            r_next_id <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_occ     <= n_occ;
            r_next_id <= n_next_id;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rptr <= n_rptr;
        r_num  <= n_num;
        r_cnt  <= n_cnt;
        r_mode <= n_mode;
        r_key  <= n_key;
        r_min  <= n_min;
        r_res  <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_occ     = r_occ;
        n_next_id = r_next_id;
        n_rptr    = r_rptr;
        n_num     = r_num;
        n_cnt     = r_cnt;
        n_mode    = r_mode;
        n_key     = r_key;
        n_min     = r_min;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = tail_slot;
        mem_wdata = {i_in_beat.key[KB-1:0], r_next_id};
        mem_re    = 1'b0;
        mem_raddr = r_head;
        res       = '0;
        res_vld   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_beat.mode)
                        MODE_PUSH: begin
                            res_vld = 1'b1;
                            if (r_occ == OW'(DEPTH)) begin
                                res.status = ST_FULL;
                            end else if (r_next_id == ID_LIMIT) begin
                                res.status = ST_IDS_OUT;
                            end else begin
                                mem_we          = 1'b1;
                                res.assigned_id = r_next_id;
                                n_next_id       = r_next_id + 1'b1;
                                n_occ           = r_occ + 1'b1;
                            end
                        end
                        MODE_COUNT_ALL: begin
                            res_vld   = 1'b1;
                            res.count = occ_ext[CNT_W-1:0];
                        end
                        MODE_COUNT_KEY, MODE_INVALIDATE: begin
                            if (r_occ == '0) begin
                                res_vld = 1'b1;
                            end else begin
                                // first read goes to the head slot
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_rptr    = ptr_inc(r_head);
                                n_num     = r_occ;
                                n_cnt     = '0;
                                n_mode    = i_in_beat.mode;
                                n_key     = i_in_beat.key[KB-1:0];
                                n_min     = i_in_beat.minimum_id;
                                n_state   = S_WALK;
                            end
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (r_mode == MODE_INVALIDATE) begin
                    if (below) begin
                        n_head = ptr_inc(r_head);
                        n_occ  = r_occ - 1'b1;
                    end
                    if (!below || r_num == OW'(1)) begin
                        res_vld = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rptr;
                        n_rptr    = ptr_inc(r_rptr);
                        n_num     = r_num - 1'b1;
                    end
                end else begin
                    n_cnt = cnt_nxt;
                    if (r_num == OW'(1)) begin
                        res_vld   = 1'b1;
                        res.count = cnt_ext[CNT_W-1:0];
                        n_state   = S_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_rptr;
                        n_rptr    = ptr_inc(r_rptr);
                        n_num     = r_num - 1'b1;
                    end
                end
            end
            S_HOLD: begin
                res_vld = 1'b1;
                res     = r_res;
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output stage busy: park the finished result
        if (r_state != S_HOLD && res_vld && !i_res_free) begin
            n_res   = res;
            n_state = S_HOLD;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_res_vld  = res_vld;
    assign o_res      = res;

endmodule
`default_nettype wire

FILE: design/sequenced_tagged_fifo_top.sv
// sequenced tagged fifo
// input channel: i_in_valid / o_in_stall carry one command beat (mode, key,
// minimum_id); output channel: o_out_valid / i_out_stall carry one result
// beat (count, assigned_id, status) for every command, in command order.
// push stores the key with the next sequence id and returns that id, or
// status full / ids exhausted; count-all returns the occupancy; count-key
// and invalidate walk the stored entries from the head.
// push and count-all: the result is loaded into the output register at the
// accepting edge, so one such beat per cycle while the receiver keeps up.
// count-key walks every occupied entry; invalidate walks from the head and
// stops at the first entry not below minimum_id or when all are removed;
// the walk reads the entry memory one slot per cycle through its single
// read port.
// one command is in work at a time; input stall is high while a walk runs
// or while a finished result waits behind a full output register.
// reset clears head, occupancy and the id counter; entry memory is not
// cleared, only occupied slots are ever read.
// a stalled receiver holds the output register; the next command is still
// taken and its result is parked inside until the register frees up.
`default_nettype none
module sequenced_tagged_fifo_top
    import stf_pkg::*;
#(
    parameter int DEPTH    = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_stf_in i_in_beat,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_stf_out     o_out_beat
);

    logic     res_vld;
    t_stf_out res;
    logic     res_free;
    logic     r_out_vld;
    t_stf_out r_out_beat;

    // output register can take a beat when empty or being drained
    assign res_free = !r_out_vld || !i_out_stall;

    stf_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_beat  (i_in_beat),
        .o_res_vld  (res_vld),
        .o_res      (res),
        .i_res_free (res_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_free) begin
            r_out_vld <= res_vld;
        end
    end

    // payload moves only with a new beat, so a stalled beat holds
    always_ff @(posedge i_clk) begin
        if (res_free && res_vld) begin
            r_out_beat <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

endmodule
`default_nettype wire
